[rtl/sha1md_pkg.sv]
`timescale 1ns / 1ps
package sha1md_pkg;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] ROUND_K [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] BLOCK_LAST = 6'd63;
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [2:0] WORD_LAST  = 3'd4;

  // byte source select
  localparam logic [1:0] SEL_IN    = 2'd0;
  localparam logic [1:0] SEL_PAD80 = 2'd1;
  localparam logic [1:0] SEL_ZERO  = 2'd2;
  localparam logic [1:0] SEL_LEN   = 2'd3;

  // round function group
  localparam logic [1:0] GRP_CH  = 2'd0;
  localparam logic [1:0] GRP_P1  = 2'd1;
  localparam logic [1:0] GRP_MAJ = 2'd2;
  localparam logic [1:0] GRP_P3  = 2'd3;

  typedef struct packed {
    logic       byte_we;
    logic [1:0] byte_sel;
    logic       len_inc;
    logic       load_work;
    logic       round_en;
    logic [1:0] round_grp;
    logic       chain_add;
    logic [2:0] out_idx;
    logic       msg_clear;
  } sha1md_cmd_t;

  typedef struct packed {
    logic [5:0] byte_pos;
  } sha1md_stat_t;

endpackage

[rtl/sha1_message_digest.sv]
`timescale 1ns / 1ps
// SHA-1 digest of a byte stream, one message byte per input item (tuser = 1),
// tlast marking the end of the message; a bare end mark (tuser = 0, tlast = 1)
// allows the empty message. The 64th byte of a block starts the compression:
// 80 rounds at one round per cycle on a single round unit, then the chaining
// add, during which no item is taken. At end of message the padding bytes
// (0x80, zeros, 64-bit bit length) are fed one per cycle, with one or two
// more compressions, after which the five digest words come out most
// significant first, one per accepted output cycle. Input is held off from
// end of message until the last digest word is taken; then the block is ready
// for the next message with fresh initial chaining values.
module sha1_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // has_byte
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero above
  output logic        m_tlast    // last_word
);
  import sha1md_pkg::*;

  sha1md_cmd_t  cmd;
  sha1md_stat_t stat;
  logic [31:0]  digest_word;

  sha1md_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .stat     (stat)
  );

  sha1md_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (s_tdata),
    .cmd         (cmd),
    .stat        (stat),
    .digest_word (digest_word)
  );

  assign m_tdata = {5'd0, cmd.out_idx, digest_word};

endmodule

[rtl/sha1md_dp.sv]
`timescale 1ns / 1ps
module sha1md_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [7:0]               data_byte,
  input  sha1md_pkg::sha1md_cmd_t  cmd,
  output sha1md_pkg::sha1md_stat_t stat,
  output logic [31:0]              digest_word
);
  import sha1md_pkg::*;

  logic [31:0] chain [5];
  logic [31:0] win [16];
  logic [31:0] wa, wb, wc, wd, we;
  logic [23:0] acc;
  logic [5:0]  byte_pos;
  logic [63:0] bit_len;

  logic [7:0]  byte_val;
  logic [31:0] word_full;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] tmp;
  logic [31:0] sched_x;
  logic [31:0] sched_new;

  always_comb begin
    case (cmd.byte_sel)
      SEL_IN:    byte_val = data_byte;
      SEL_PAD80: byte_val = PAD_BYTE;
      SEL_ZERO:  byte_val = 8'h00;
      SEL_LEN:   byte_val = bit_len[63:56];
      default:   byte_val = 8'h00;
    endcase
  end

  assign word_full = {acc, byte_val};

  always_comb begin
    case (cmd.round_grp)
      GRP_CH:  f_val = (wb & wc) | (~wb & wd);
      GRP_MAJ: f_val = (wb & wc) | (wb & wd) | (wc & wd);
      default: f_val = wb ^ wc ^ wd;
    endcase
    k_val = ROUND_K[cmd.round_grp];
  end

  assign tmp       = {wa[26:0], wa[31:27]} + f_val + we + k_val + win[0];
  assign sched_x   = win[13] ^ win[8] ^ win[2] ^ win[0];
  assign sched_new = {sched_x[30:0], sched_x[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos <= '0;
      bit_len  <= '0;
      for (int i = 0; i < 5; i++) chain[i] <= H_INIT[i];
    end else if (cmd.msg_clear) begin
      byte_pos <= '0;
      bit_len  <= '0;
      for (int i = 0; i < 5; i++) chain[i] <= H_INIT[i];
    end else begin
      if (cmd.byte_we) begin
        byte_pos <= byte_pos + 6'd1;
      end
      if (cmd.len_inc) begin
        bit_len <= bit_len + 64'd8;
      end else if (cmd.byte_we && cmd.byte_sel == SEL_LEN) begin
        bit_len <= {bit_len[55:0], 8'h00};
      end
      if (cmd.chain_add) begin
        chain[0] <= chain[0] + wa;
        chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc;
        chain[3] <= chain[3] + wd;
        chain[4] <= chain[4] + we;
      end
    end
  end

  // byte packing, schedule window and round registers
  always_ff @(posedge clk) begin
    if (cmd.byte_we) begin
      acc <= word_full[23:0];
      if (byte_pos[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) win[i] <= win[i+1];
        win[15] <= word_full;
      end
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i+1];
      win[15] <= sched_new;
    end
    if (cmd.load_work) begin
      wa <= chain[0];
      wb <= chain[1];
      wc <= chain[2];
      wd <= chain[3];
      we <= chain[4];
    end else if (cmd.round_en) begin
      we <= wd;
      wd <= wc;
      wc <= {wb[1:0], wb[31:2]};
      wb <= wa;
      wa <= tmp;
    end
  end

  always_comb begin
    case (cmd.out_idx)
      3'd0:    digest_word = chain[0];
      3'd1:    digest_word = chain[1];
      3'd2:    digest_word = chain[2];
      3'd3:    digest_word = chain[3];
      default: digest_word = chain[4];
    endcase
  end

  assign stat.byte_pos = byte_pos;

endmodule

[rtl/sha1md_ctrl.sv]
`timescale 1ns / 1ps
module sha1md_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic                     s_tuser,
  input  logic                     s_tlast,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic                     m_tlast,
  output sha1md_pkg::sha1md_cmd_t  cmd,
  input  sha1md_pkg::sha1md_stat_t stat
);
  import sha1md_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FINAL = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state, state_next;
  logic [6:0] round_cnt, round_cnt_next;
  logic [2:0] out_idx, out_idx_next;
  logic       padding, padding_next;
  logic       sent80, sent80_next;
  logic       need_wrap, need_wrap_next;
  logic       last_block, last_block_next;
  logic       blk_end;
  logic       at_len;

  assign blk_end = stat.byte_pos == BLOCK_LAST;
  assign at_len  = stat.byte_pos >= LEN_POS;

  assign s_tready = state == ST_IDLE;
  assign m_tvalid = state == ST_OUT;
  assign m_tlast  = m_tvalid && out_idx == WORD_LAST;

  always_comb begin
    cmd             = '0;
    cmd.out_idx     = out_idx;
    state_next      = state;
    round_cnt_next  = round_cnt;
    out_idx_next    = out_idx;
    padding_next    = padding;
    sent80_next     = sent80;
    need_wrap_next  = need_wrap;
    last_block_next = last_block;

    if (round_cnt < 7'd20) begin
      cmd.round_grp = GRP_CH;
    end else if (round_cnt < 7'd40) begin
      cmd.round_grp = GRP_P1;
    end else if (round_cnt < 7'd60) begin
      cmd.round_grp = GRP_MAJ;
    end else begin
      cmd.round_grp = GRP_P3;
    end

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser) begin
            cmd.byte_we  = 1'b1;
            cmd.byte_sel = SEL_IN;
            cmd.len_inc  = 1'b1;
          end
          if (s_tlast) begin
            padding_next = 1'b1;
            state_next   = ST_PAD;
          end
          if (s_tuser && blk_end) begin
            cmd.load_work = 1'b1;
            state_next    = ST_ROUND;
          end
        end
      end
      ST_PAD: begin
        cmd.byte_we = 1'b1;
        if (!sent80) begin
          cmd.byte_sel   = SEL_PAD80;
          sent80_next    = 1'b1;
          // marker landed in the length field: length goes in the next block
          need_wrap_next = at_len;
        end else if (!need_wrap && at_len) begin
          cmd.byte_sel = SEL_LEN;
          if (blk_end) last_block_next = 1'b1;
        end else begin
          cmd.byte_sel = SEL_ZERO;
        end
        if (blk_end) begin
          cmd.load_work  = 1'b1;
          need_wrap_next = 1'b0;
          state_next     = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round_en   = 1'b1;
        round_cnt_next = round_cnt + 7'd1;
        if (round_cnt == ROUND_LAST) begin
          round_cnt_next = '0;
          state_next     = ST_FINAL;
        end
      end
      ST_FINAL: begin
        cmd.chain_add = 1'b1;
        if (last_block) begin
          out_idx_next = '0;
          state_next   = ST_OUT;
        end else if (padding) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (m_tready) begin
          if (out_idx == WORD_LAST) begin
            cmd.msg_clear   = 1'b1;
            out_idx_next    = '0;
            padding_next    = 1'b0;
            sent80_next     = 1'b0;
            need_wrap_next  = 1'b0;
            last_block_next = 1'b0;
            state_next      = ST_IDLE;
          end else begin
            out_idx_next = out_idx + 3'd1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      round_cnt  <= '0;
      out_idx    <= '0;
      padding    <= 1'b0;
      sent80     <= 1'b0;
      need_wrap  <= 1'b0;
      last_block <= 1'b0;
    end else begin
      state      <= state_next;
      round_cnt  <= round_cnt_next;
      out_idx    <= out_idx_next;
      padding    <= padding_next;
      sent80     <= sent80_next;
      need_wrap  <= need_wrap_next;
      last_block <= last_block_next;
    end
  end

endmodule

[rtl/sha1md_chk.sv]
`timescale 1ns / 1ps
module sha1md_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("digest word changed while stalled");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd4)))
    else $error("tlast does not match final word index");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1)
    else $error("digest words not consecutive");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while digest pending");

endmodule

bind sha1_message_digest sha1md_chk u_sha1md_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

[dv/sha1_digest_checker.sv]
`timescale 1ns / 1ps
module sha1_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // has_byte
  input  logic        s_tlast,   // end_of_message
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero above
  input  logic        m_tlast,   // last_word
  output int          errors,
  output int          pending
);

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;
  localparam logic [31:0] K_CH  = 32'h5A827999;
  localparam logic [31:0] K_P1  = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
  localparam logic [31:0] K_P3  = 32'hCA62C1D6;
  localparam logic [7:0]  MARK_BYTE   = 8'h80;
  localparam logic [5:0]  LENGTH_SLOT = 6'd56;
  localparam int          MAX_REPORTS = 10;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  pos;
    logic        last;
  } digest_word_t;

  logic [31:0]  chain [5];
  logic [31:0]  sched [16];
  logic [5:0]   fill_pos;
  logic [63:0]  msg_bits;
  digest_word_t digest_q [$];

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic restart_digest();
    chain[0] = IV0;
    chain[1] = IV1;
    chain[2] = IV2;
    chain[3] = IV3;
    chain[4] = IV4;
    fill_pos = '0;
    msg_bits = '0;
  endtask

  task automatic absorb_block();
    logic [31:0] a, b, c, d, e, f, k, w, t;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        w = sched[(r - 3) & 15] ^ sched[(r - 8) & 15] ^ sched[(r - 14) & 15] ^ sched[r & 15];
        sched[r & 15] = rol(w, 1);
      end
      w = sched[r & 15];
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_CH;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_P1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = K_P3;
      end
      t = rol(a, 5) + f + e + k + w;
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
    chain[4] = chain[4] + e;
  endtask

  // first byte of a word replaces the whole word
  task automatic push_msg_byte(input logic [7:0] b);
    int idx;
    idx = fill_pos[5:2];
    if (fill_pos[1:0] == 2'd0)
      sched[idx] = {b, 24'h0};
    else
      sched[idx] = sched[idx] | ({24'h0, b} << (24 - 8 * fill_pos[1:0]));
    fill_pos = fill_pos + 6'd1;
    if (fill_pos == 6'd0)
      absorb_block();
  endtask

  task automatic finish_digest();
    logic [63:0]  bits;
    digest_word_t dw;
    bits = msg_bits;
    push_msg_byte(MARK_BYTE);
    while (fill_pos != LENGTH_SLOT)
      push_msg_byte(8'h00);
    for (int j = 7; j >= 0; j--)
      push_msg_byte(bits[8 * j +: 8]);
    for (int j = 0; j < 5; j++) begin
      dw.word = chain[j];
      dw.pos  = 3'(j);
      dw.last = (j == 4);
      digest_q.push_back(dw);
    end
    restart_digest();
  endtask

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (rst) begin
      restart_digest();
      digest_q.delete();
      errors <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (s_tuser) begin
          push_msg_byte(s_tdata);
          msg_bits = msg_bits + 64'd8;
        end
        if (s_tlast)
          finish_digest();
      end
      if (m_tvalid && m_tready) begin
        if (digest_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < MAX_REPORTS)
            $display("%0t: unexpected digest item word=%h idx=%0d last=%b", $realtime,
                     m_tdata[31:0], m_tdata[34:32], m_tlast);
        end else begin
          exp_w = digest_q.pop_front();
          if (m_tdata[31:0] !== exp_w.word || m_tdata[39:32] !== {5'b0, exp_w.pos} ||
              m_tlast !== exp_w.last) begin
            errors <= errors + 1;
            if (errors < MAX_REPORTS)
              $display("%0t: digest mismatch exp word=%h idx=%0d last=%b got word=%h hi=%h last=%b",
                       $realtime, exp_w.word, exp_w.pos, exp_w.last,
                       m_tdata[31:0], m_tdata[39:32], m_tlast);
          end
        end
      end
    end
    pending <= digest_q.size();
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

  localparam int RESET_CYCLES = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 100;
  localparam int ITEM_TARGET  = 180;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tuser  = 1'b0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  int errors;
  int pending;
  int items_sent    = 0;
  int idle_cycles   = 0;
  bit hold_off_req  = 1'b0;
  bit hold_off_done = 1'b0;

  always #5 clk = ~clk;

  sha1_message_digest u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  sha1_digest_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .errors   (errors),
    .pending  (pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic has, input logic eom);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= has;
    s_tlast  <= eom;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic pause_sender();
    if ($urandom_range(0, 2) == 0) begin
      s_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  // random bytes, optional bare end mark, ignored items sprinkled in as noise
  task automatic send_message(input int len, input bit bare_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(8'($urandom), 1'b0, 1'b0);
        pause_sender();
      end
      send_item(8'($urandom), 1'b1, !bare_end && (i == len - 1));
      items_sent++;
      pause_sender();
    end
    if (bare_end || len == 0) begin
      send_item(8'($urandom), 1'b0, 1'b1);
      items_sent++;
      pause_sender();
    end
  endtask

  initial begin : stimulus
    int len;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty message
    send_item(8'h00, 1'b0, 1'b1);
    // ignored item, then a single 0xFF ending on its own byte
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    // single zero byte closed by a bare end mark
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    pause_sender();
    // "abc"
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // single-bit and alternating bit patterns with an ignored item before the end mark
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'hAA, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h7F, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    items_sent += 12;

    hold_off_req = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      // lengths around the padding and block boundaries now and then
      case ($urandom_range(0, 5))
        0:       len = 55 + $urandom_range(0, 1);
        1:       len = 63 + $urandom_range(0, 1);
        default: len = $urandom_range(0, 12);
      endcase
      send_message(len, $urandom_range(0, 2) == 0);
    end
    s_tvalid <= 1'b0;

    // let the checker's count catch up with the last accepted item
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin : digest_sink
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
